// ===== rtl/pcv_pkg.sv =====
// ----------------------------------------------------------------------------
// pcv_pkg
// Shared types, constants and table functions of the power-curve oscillator.
// ----------------------------------------------------------------------------
package pcv_pkg;

    localparam int CHANNELS_DEF    = 16;
    localparam int SAMPLE_RATE_DEF = 48000;

    // Configuration register indexes.
    localparam logic [2:0] REG_COARSE = 3'd0;
    localparam logic [2:0] REG_POW_1  = 3'd1;
    localparam logic [2:0] REG_POW_2  = 3'd2;
    localparam logic [2:0] REG_POW_3  = 3'd3;
    localparam logic [2:0] REG_POW_4  = 3'd4;
    localparam logic [2:0] REG_DIV    = 3'd5;
    localparam logic [2:0] REG_MODE   = 3'd6;

    localparam logic signed [10:0] COARSE_RST = 11'sd0;
    localparam logic signed [14:0] POW_RST    = 15'sd2048;
    localparam logic [7:0]         DIV_RST    = 8'd1;
    localparam logic [1:0]         MODE_RST   = 2'd2;

    // 10240 * C4 in Q16, the numerator constant of the phase increment.
    localparam logic [63:0] K_BASE = 64'd175573944320;
    localparam logic [63:0] WRAP   = 64'd671088640;
    localparam logic [29:0] SEG    = 30'd167772160;
    // log2 of one segment length, Q16.
    localparam logic [21:0] LSEG   = 22'd1790570;
    localparam logic [24:0] PCAP   = 25'd16777216;

    localparam int DVDW      = 55;
    localparam int MUL1_STEPS = 17;
    localparam int MUL2_STEPS = 16;
    localparam int MOD_TOP    = 17;

    localparam logic ALU_ADD  = 1'b0;
    localparam logic ALU_CSUB = 1'b1;

    localparam logic [1:0] PV_NORM = 2'd0;
    localparam logic [1:0] PV_CAP  = 2'd1;
    localparam logic [1:0] PV_ZERO = 2'd2;

    typedef struct packed {
        logic        op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    function automatic logic [17:0] exp_tab(input logic [4:0] k);
        logic [17:0] v;
        case (k)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] log_tab(input logic [4:0] k);
        logic [17:0] v;
        case (k)
            5'd0:    v = 18'd0;
            5'd1:    v = 18'd5732;
            5'd2:    v = 18'd11136;
            5'd3:    v = 18'd16248;
            5'd4:    v = 18'd21098;
            5'd5:    v = 18'd25711;
            5'd6:    v = 18'd30109;
            5'd7:    v = 18'd34312;
            5'd8:    v = 18'd38336;
            5'd9:    v = 18'd42196;
            5'd10:   v = 18'd45904;
            5'd11:   v = 18'd49472;
            5'd12:   v = 18'd52911;
            5'd13:   v = 18'd56229;
            5'd14:   v = 18'd59434;
            5'd15:   v = 18'd62534;
            default: v = 18'd65536;
        endcase
        return v;
    endfunction

    // Linear interpolation between table points, sixteen steps over a Q16 fraction.
    function automatic logic [17:0] interp(input logic sel_log, input logic [15:0] x);
        logic [4:0]  k;
        logic [17:0] lo;
        logic [17:0] hi;
        logic [29:0] prod;
        k    = {1'b0, x[15:12]};
        lo   = sel_log ? log_tab(k) : exp_tab(k);
        hi   = sel_log ? log_tab(k + 5'd1) : exp_tab(k + 5'd1);
        prod = 30'(hi - lo) * 30'(x[11:0]);
        return lo + prod[29:12];
    endfunction

endpackage

// ===== rtl/pcv_if.sv =====
// ----------------------------------------------------------------------------
// pcv_in_if
// Input channel: one sample request word per handshake.
// ----------------------------------------------------------------------------
interface pcv_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         channel;
    logic signed [16:0] pitch_cv;
    logic signed [14:0] pow_cv_1;
    logic signed [14:0] pow_cv_2;
    logic signed [14:0] pow_cv_3;
    logic signed [14:0] pow_cv_4;
    logic               sync_reset;

    modport source (output valid, channel, pitch_cv, pow_cv_1, pow_cv_2, pow_cv_3,
                    pow_cv_4, sync_reset, input ready);
    modport sink (input valid, channel, pitch_cv, pow_cv_1, pow_cv_2, pow_cv_3,
                  pow_cv_4, sync_reset, output ready);
endinterface

// ===== rtl/pcv_out_if.sv =====
// ----------------------------------------------------------------------------
// pcv_out_if
// Output channel: one sample word per handshake.
// ----------------------------------------------------------------------------
interface pcv_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         voice;
    logic signed [16:0] wave;

    modport source (output valid, voice, wave, input ready);
    modport sink (input valid, voice, wave, output ready);
endinterface

// ===== rtl/pcv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pcv_cfg_if
// Configuration write channel: register index and data per word.
// ----------------------------------------------------------------------------
interface pcv_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [14:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/power_curve_vco_core.sv =====
// ----------------------------------------------------------------------------
// power_curve_vco_core
// Polyphonic power-curve oscillator: one sample word out per request word.
// ----------------------------------------------------------------------------
//  port    dir  modport  word
//  i_in    in   sink     channel, pitch, exponent offsets, sync
//  o_out   out  source   voice, wave sample
//  i_cfg   in   sink     register index, data (always ready)
//
//  A word takes longer when the phase wraps, and less time when the curve position
//  is zero or the envelope has ended.
//  A 17-step multiply, a 55-step divide, the wrap steps and a 16-step multiply
//  all run on the one shared 64-bit adder.
//  i_rst_n is synchronous; it clears all phases through the valid bits at once.
//  The output register lets a new word enter while a sample waits; a finished
//  sample stalls the sequencer only while that register is still full.
// ----------------------------------------------------------------------------
module power_curve_vco_core #(
    parameter int CHANNELS    = pcv_pkg::CHANNELS_DEF,
    parameter int SAMPLE_RATE = pcv_pkg::SAMPLE_RATE_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pcv_in_if.sink   i_in,
    pcv_out_if.source o_out,
    pcv_cfg_if.sink  i_cfg
);

    localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DENW = $clog2(SAMPLE_RATE * 255 + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PIT   = 4'd1;
    localparam logic [3:0] S_FRQ   = 4'd2;
    localparam logic [3:0] S_VEX   = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_ADD   = 4'd6;
    localparam logic [3:0] S_MOD   = 4'd7;
    localparam logic [3:0] S_SEG   = 4'd8;
    localparam logic [3:0] S_NORM  = 4'd9;
    localparam logic [3:0] S_LOG   = 4'd10;
    localparam logic [3:0] S_MUL2  = 4'd11;
    localparam logic [3:0] S_EXPQ  = 4'd12;
    localparam logic [3:0] S_POW   = 4'd13;
    localparam logic [3:0] S_SHAPE = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    // Configuration registers.
    logic signed [10:0] r_coarse;
    logic signed [14:0] r_pbase [4];
    logic [7:0]         r_div;
    logic [1:0]         r_mode;

    // Sequencer and datapath registers.
    logic [3:0]         r_state;
    logic [5:0]         r_cnt;
    logic [63:0]        r_acc;
    logic [63:0]        r_mcand;
    logic [16:0]        r_mplier;
    logic [3:0]         r_ch;
    logic [IDXW-1:0]    r_idx;
    logic signed [14:0] r_pcv [4];
    logic [19:0]        r_pp;
    logic [5:0]         r_nq;
    logic [13:0]        r_f;
    logic [15:0]        r_x16;
    logic [DENW-1:0]    r_den;
    logic [27:0]        r_t;
    logic [4:0]         r_b;
    logic signed [15:0] r_e;
    logic               r_neg;
    logic               r_sgn;
    logic [21:0]        r_qq;
    logic [1:0]         r_pvsel;
    logic [24:0]        r_pv;
    logic signed [16:0] r_res;

    logic               r_ovalid;
    logic [3:0]         r_ovoice;
    logic signed [16:0] r_owave;

    logic               in_acc;
    logic               done_fire;
    logic [IDXW-1:0]    idx_map [16];
    logic [31:0]        phase_rd;
    logic               st_wr;

    pcv_pkg::t_alu_req  alu_req;
    logic [63:0]        alu_res;
    logic               alu_ge;

    // Channel to phase slot, folded at elaboration.
    for (genvar g = 0; g < 16; g++) begin : g_map
        assign idx_map[g] = IDXW'(g % CHANNELS);
    end

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign st_wr      = (r_state == S_SEG);
    assign done_fire  = (r_state == S_DONE) && (!r_ovalid || o_out.ready);

    pcv_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res),
        .o_ge  (alu_ge)
    );

    pcv_phase_store #(
        .CHANNELS (CHANNELS),
        .IDXW     (IDXW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (in_acc && i_in.sync_reset),
        .i_rd_en   (in_acc),
        .i_rd_addr (idx_map[i_in.channel]),
        .o_rd_data (phase_rd),
        .i_wr_en   (st_wr),
        .i_wr_addr (r_idx),
        .i_wr_data (r_acc[31:0])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse <= pcv_pkg::COARSE_RST;
            for (int i = 0; i < 4; i++) r_pbase[i] <= pcv_pkg::POW_RST;
            r_div  <= pcv_pkg::DIV_RST;
            r_mode <= pcv_pkg::MODE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pcv_pkg::REG_COARSE: r_coarse   <= i_cfg.data[10:0];
                pcv_pkg::REG_POW_1:  r_pbase[0] <= i_cfg.data;
                pcv_pkg::REG_POW_2:  r_pbase[1] <= i_cfg.data;
                pcv_pkg::REG_POW_3:  r_pbase[2] <= i_cfg.data;
                pcv_pkg::REG_POW_4:  r_pbase[3] <= i_cfg.data;
                pcv_pkg::REG_DIV:    r_div      <= i_cfg.data[7:0];
                pcv_pkg::REG_MODE:   r_mode     <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    // Combinational helpers for the individual steps.
    logic signed [20:0] pp_s;
    logic [16:0]        nq_prod;
    logic [5:0]         nq_w;
    logic [37:0]        x_prod;
    logic [17:0]        vex_w;
    logic [63:0]        quot;
    logic [63:0]        inc;
    logic [29:0]        x;
    logic [29:0]        t_w;
    logic signed [15:0] e_w;
    logic               neg_w;
    logic [4:0]         amt;
    logic [27:0]        t_hi;
    logic [21:0]        logv;
    logic signed [22:0] l_s;
    logic [20:0]        l_abs;
    logic [16:0]        e_abs;
    logic [26:0]        qmag;
    logic [17:0]        pv_v;
    logic [5:0]         ip;
    logic [24:0]        pv_w;
    logic [28:0]        pv10;
    logic signed [25:0] y0, y1, y2, y3, y4;
    logic signed [16:0] wave_w;
    logic               env;

    assign env = r_mode[0];

    always_comb begin
        pp_s = 21'(i_in.pitch_cv) * 21'sd3 + (21'(r_coarse) <<< 6) + 21'sd270336;
        // Octave index: (pp >> 12) / 3 by reciprocal.
        nq_prod = 17'(r_pp[19:12]) * 17'd171;
        nq_w    = nq_prod[14:9];
        x_prod  = 38'({r_f, 4'b0}) * 38'd174763;
        vex_w   = pcv_pkg::interp(1'b0, r_x16);

        quot = {9'b0, r_mcand[pcv_pkg::DVDW-1:0]};
        if (r_nq >= 6'd38) inc = quot << (r_nq - 6'd38);
        else               inc = quot >> (6'd38 - r_nq);

        x = r_acc[29:0];
        if (!env) begin
            if (x <= pcv_pkg::SEG) begin
                t_w = pcv_pkg::SEG - x;
                e_w = 16'(r_pbase[0]) + 16'(r_pcv[0]);
                neg_w = 1'b0;
            end else if (x < 30'(2) * pcv_pkg::SEG) begin
                t_w = x - pcv_pkg::SEG;
                e_w = 16'(r_pbase[1]) + 16'(r_pcv[1]);
                neg_w = 1'b0;
            end else if (x < 30'(3) * pcv_pkg::SEG) begin
                t_w = 30'(3) * pcv_pkg::SEG - x;
                e_w = 16'(r_pbase[2]) + 16'(r_pcv[2]);
                neg_w = 1'b1;
            end else begin
                t_w = x - 30'(3) * pcv_pkg::SEG;
                e_w = 16'(r_pbase[3]) + 16'(r_pcv[3]);
                neg_w = 1'b1;
            end
        end else begin
            if (x <= pcv_pkg::SEG) begin
                t_w = x;
                e_w = 16'(r_pbase[0]) + 16'(r_pcv[0]);
                neg_w = 1'b1;
            end else if (x < 30'(2) * pcv_pkg::SEG) begin
                t_w = 30'(2) * pcv_pkg::SEG - x;
                e_w = 16'(r_pbase[1]) + 16'(r_pcv[1]);
                neg_w = 1'b0;
            end else if (x < 30'(3) * pcv_pkg::SEG) begin
                t_w = x - 30'(2) * pcv_pkg::SEG;
                e_w = 16'(r_pbase[2]) + 16'(r_pcv[2]);
                neg_w = 1'b0;
            end else begin
                t_w = 30'(4) * pcv_pkg::SEG - x;
                e_w = 16'(r_pbase[3]) + 16'(r_pcv[3]);
                neg_w = 1'b1;
            end
        end

        amt  = 5'd16 >> r_cnt[2:0];
        t_hi = r_t >> (5'd28 - amt);

        logv  = {1'b0, r_b, 16'b0} + 22'(pcv_pkg::interp(1'b1, r_t[26:11]));
        l_s   = $signed({1'b0, logv}) - $signed({1'b0, pcv_pkg::LSEG});
        if (l_s > 23'sd0) l_s = 23'sd0;
        l_abs = 21'(-l_s);
        e_abs = r_e[15] ? 17'(-(17'(r_e))) : 17'(r_e);

        qmag = r_acc[36:10];

        pv_v = pcv_pkg::interp(1'b0, r_qq[15:0]);
        ip   = r_qq[21:16];
        if (ip >= 6'd40) pv_w = 25'(pv_v) << (ip - 6'd40);
        else             pv_w = 25'(pv_v) >> (6'd40 - ip);

        pv10 = 29'(r_pv) * 29'd10;
        y0 = $signed({3'b0, pv10[28:6]}) - 26'sd10240;
        y1 = r_neg ? -y0 : y0;
        y2 = y1;
        if (r_mode[1]) begin
            if (y1 < -26'sd10240) y2 = -26'sd10240;
            if (y1 > 26'sd10240)  y2 = 26'sd10240;
        end
        y3 = env ? (26'sd10240 - y2) : y2;
        // Halve with truncation toward zero.
        y4 = (y3 + $signed({25'b0, y3[25]})) >>> 1;
        if (y4 < -26'sd65536)     wave_w = -17'sd65536;
        else if (y4 > 26'sd65535) wave_w = 17'sd65535;
        else                      wave_w = y4[16:0];
    end

    // Operand routing for the shared adder.
    always_comb begin
        alu_req.op = pcv_pkg::ALU_ADD;
        alu_req.a  = r_acc;
        alu_req.b  = 64'd0;
        case (r_state)
            S_MUL1, S_MUL2: begin
                alu_req.b = r_mplier[0] ? r_mcand : 64'd0;
            end
            S_DIV: begin
                alu_req.op = pcv_pkg::ALU_CSUB;
                alu_req.a  = {r_acc[62:0], r_mcand[pcv_pkg::DVDW-1]};
                alu_req.b  = 64'(r_den);
            end
            S_ADD: begin
                alu_req.a = {32'b0, phase_rd};
                alu_req.b = inc;
            end
            S_MOD: begin
                alu_req.op = pcv_pkg::ALU_CSUB;
                alu_req.b  = pcv_pkg::WRAP << r_cnt;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ch    <= i_in.channel;
                        r_idx   <= idx_map[i_in.channel];
                        r_pcv[0] <= i_in.pow_cv_1;
                        r_pcv[1] <= i_in.pow_cv_2;
                        r_pcv[2] <= i_in.pow_cv_3;
                        r_pcv[3] <= i_in.pow_cv_4;
                        r_pp    <= pp_s[19:0];
                        r_den   <= DENW'(SAMPLE_RATE) *
                                   DENW'((r_div == 8'd0) ? 8'd1 : r_div);
                        r_state <= S_PIT;
                    end
                end
                S_PIT: begin
                    r_nq    <= nq_w;
                    r_f     <= 14'(r_pp - 20'(nq_w) * 20'd12288);
                    r_state <= S_FRQ;
                end
                S_FRQ: begin
                    r_x16   <= x_prod[34:19];
                    r_state <= S_VEX;
                end
                S_VEX: begin
                    r_mplier <= vex_w[16:0];
                    r_mcand  <= pcv_pkg::K_BASE;
                    r_acc    <= 64'd0;
                    r_cnt    <= 6'(pcv_pkg::MUL1_STEPS);
                    r_state  <= S_MUL1;
                end
                S_MUL1: begin
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == 6'd1) begin
                        // Product becomes the dividend; the remainder starts empty.
                        r_mcand <= alu_res;
                        r_acc   <= 64'd0;
                        r_cnt   <= 6'(pcv_pkg::DVDW);
                        r_state <= S_DIV;
                    end else begin
                        r_acc   <= alu_res;
                        r_mcand <= r_mcand << 1;
                        r_cnt   <= r_cnt - 6'd1;
                    end
                end
                S_DIV: begin
                    r_acc   <= alu_res;
                    r_mcand <= {r_mcand[62:0], alu_ge};
                    r_cnt   <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc <= alu_res;
                    if (alu_res > pcv_pkg::WRAP) begin
                        if (env) begin
                            // End of the envelope: no phase update and a silent sample.
                            r_res   <= 17'sd0;
                            r_state <= S_DONE;
                        end else begin
                            r_cnt   <= 6'(pcv_pkg::MOD_TOP);
                            r_state <= S_MOD;
                        end
                    end else begin
                        r_state <= S_SEG;
                    end
                end
                S_MOD: begin
                    r_acc <= alu_res;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) r_state <= S_SEG;
                end
                S_SEG: begin
                    r_e   <= e_w;
                    r_neg <= neg_w;
                    r_t   <= t_w[27:0];
                    r_b   <= 5'd27;
                    r_cnt <= 6'd0;
                    if (t_w == 30'd0) begin
                        if (e_w > 16'sd0)       r_pv <= 25'd0;
                        else if (e_w == 16'sd0) r_pv <= 25'd65536;
                        else                    r_pv <= pcv_pkg::PCAP;
                        r_state <= S_SHAPE;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (t_hi == 28'd0) begin
                        r_t <= r_t << amt;
                        r_b <= r_b - amt;
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd4) r_state <= S_LOG;
                end
                S_LOG: begin
                    r_mcand  <= 64'(l_abs);
                    r_mplier <= e_abs;
                    // With log u never positive, the product is negative for e > 0.
                    r_sgn    <= ~r_e[15];
                    r_acc    <= 64'd0;
                    r_cnt    <= 6'(pcv_pkg::MUL2_STEPS);
                    r_state  <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc    <= alu_res;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) r_state <= S_EXPQ;
                end
                S_EXPQ: begin
                    if (!r_sgn && qmag >= 27'd524288) begin
                        r_pvsel <= pcv_pkg::PV_CAP;
                    end else if (r_sgn && qmag > 27'd2621440) begin
                        r_pvsel <= pcv_pkg::PV_ZERO;
                    end else begin
                        r_pvsel <= pcv_pkg::PV_NORM;
                    end
                    r_qq    <= r_sgn ? 22'(27'd2621440 - qmag) : 22'(27'd2621440 + qmag);
                    r_state <= S_POW;
                end
                S_POW: begin
                    case (r_pvsel)
                        pcv_pkg::PV_CAP:  r_pv <= pcv_pkg::PCAP;
                        pcv_pkg::PV_ZERO: r_pv <= 25'd0;
                        default:          r_pv <= pv_w;
                    endcase
                    r_state <= S_SHAPE;
                end
                S_SHAPE: begin
                    r_res   <= wave_w;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (done_fire) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register: loaded from the sequencer, emptied by the sink.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done_fire) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_ovoice <= r_ch;
            r_owave  <= r_res;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.voice = r_ovoice;
    assign o_out.wave  = r_owave;

endmodule

// ===== rtl/pcv_alu.sv =====
// ----------------------------------------------------------------------------
// pcv_alu
// Shared 64-bit adder and compare-subtract used by the multiply, divide, add and wrap steps.
// ----------------------------------------------------------------------------
module pcv_alu (
    input  pcv_pkg::t_alu_req i_req,
    output logic [63:0]       o_res,
    output logic              o_ge
);

    always_comb begin
        o_ge = (i_req.a >= i_req.b);
        case (i_req.op)
            pcv_pkg::ALU_ADD:  o_res = i_req.a + i_req.b;
            pcv_pkg::ALU_CSUB: o_res = o_ge ? (i_req.a - i_req.b) : i_req.a;
            default:           o_res = i_req.a;
        endcase
    end

endmodule

// ===== rtl/pcv_phase_store.sv =====
// ----------------------------------------------------------------------------
// pcv_phase_store
// Per-channel phase memory with valid bits; a clear empties every entry.
// ----------------------------------------------------------------------------
module pcv_phase_store #(
    parameter int CHANNELS = pcv_pkg::CHANNELS_DEF,
    parameter int IDXW     = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clr,
    input  logic            i_rd_en,
    input  logic [IDXW-1:0] i_rd_addr,
    output logic [31:0]     o_rd_data,
    input  logic            i_wr_en,
    input  logic [IDXW-1:0] i_wr_addr,
    input  logic [31:0]     i_wr_data
);

    logic [31:0]         r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    logic [31:0]         r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clr) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A clear in the same cycle as the read wins, so the phase reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= (i_clr || !r_valid[i_rd_addr]) ? 32'd0 : r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
